// ----- design/mkd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, codes, the command passed between the front and back parts,
// and the letter lookup.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int ACTION_W            = 2;
  localparam int HOLD_W              = 8;
  localparam int CHAR_W              = 7;
  localparam int SYMBOL_W            = 4;
  localparam int MAX_SYMBOLS_DEFAULT = 4;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [HOLD_W-1:0] DASH_TICKS_RESET = 8'd2;
  localparam logic [HOLD_W-1:0] HOLD_MAX         = 8'hFF;
  localparam logic [CHAR_W-1:0] SPACE_CODE       = 7'd32;
  localparam logic [CHAR_W-1:0] NO_LETTER        = 7'd0;

  // Input action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LETTER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WORD   = 2'd2;

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_KEY_DOWN = 2'd0,
    CMD_KEY_UP   = 2'd1,
    CMD_LETTER   = 2'd2,
    CMD_WORD     = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
  } cmd_t;

  // Looks up a pattern of len symbols (1 to 4), dash = 1, first symbol in
  // bit 0. Returns NO_LETTER for an unknown pattern.
  function automatic logic [CHAR_W-1:0] letter_lookup(input logic [2:0] len,
                                                      input logic [SYMBOL_W-1:0] bits);
    logic [4:0]            idx;
    logic [SYMBOL_W-1:0]   mask;
    logic [CHAR_W-1:0]     code;
    mask = 4'((5'd1 << len) - 5'd1);
    idx  = 5'((5'd1 << len) - 5'd2) + {1'b0, bits & mask};
    case (idx)
      5'd0:    code = 7'h65; // e
      5'd1:    code = 7'h74; // t
      5'd2:    code = 7'h69; // i
      5'd3:    code = 7'h6e; // n
      5'd4:    code = 7'h61; // a
      5'd5:    code = 7'h6d; // m
      5'd6:    code = 7'h73; // s
      5'd7:    code = 7'h64; // d
      5'd8:    code = 7'h72; // r
      5'd9:    code = 7'h67; // g
      5'd10:   code = 7'h75; // u
      5'd11:   code = 7'h6b; // k
      5'd12:   code = 7'h77; // w
      5'd13:   code = 7'h6f; // o
      5'd14:   code = 7'h68; // h
      5'd15:   code = 7'h62; // b
      5'd16:   code = 7'h6c; // l
      5'd17:   code = 7'h7a; // z
      5'd18:   code = 7'h66; // f
      5'd19:   code = 7'h63; // c
      5'd20:   code = 7'h70; // p
      5'd22:   code = 7'h76; // v
      5'd23:   code = 7'h78; // x
      5'd25:   code = 7'h71; // q
      5'd27:   code = 7'h79; // y
      5'd28:   code = 7'h6a; // j
      default: code = NO_LETTER;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- design/mkd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder channels
// Valid/ready channels for key requests, decoded characters and the
// configuration write.
// ----------------------------------------------------------------------------
interface mkd_key_if import mkd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                key_down;

  modport source (output valid, output action, output key_down, input ready);
  modport sink   (input valid, input action, input key_down, output ready);
endinterface

interface mkd_char_if import mkd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface mkd_cfg_if import mkd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HOLD_W-1:0] dash_ticks;

  modport source (output valid, output dash_ticks, input ready);
  modport sink   (input valid, input dash_ticks, output ready);
endinterface
`default_nettype wire

// ----- design/morse_key_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder
// Times key presses from polled samples, builds dot/dash patterns and emits
// lower-case ASCII letters and word spaces.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload               Meaning of one request
//   key_req    in         action, key_down      key sample, letter end or word end
//   char_rsp   out        character             decoded letter or space (32)
//   cfg        in         dash_ticks            new dash threshold
//
// The decoder takes one key request per cycle while the command queue has
// room. The front part classifies the request and pushes it into a two-entry
// command queue; the back part executes one command per cycle unless a held
// output stalls it. Each character passes through the queue and then the
// output register. Requests keep flowing while a character waits at the output:
// only letter and word commands stall behind a held output register. The
// queue then fills with the stalled command and one request behind it, and
// key_req.ready drops until the output register empties.
// Reset (synchronous, rst high) empties the queue, clears the symbols and
// the press timer, and sets dash_ticks to 2. The configuration port is
// always ready.
//
// Behavior: a held key counts ticks; the first tick on which the count
// exceeds dash_ticks adds one dash for that press. A release after a press
// that made no dash adds a dot. Letter end looks up the collected pattern
// (up to four symbols) and emits the letter if it is known; in every case
// the symbols are cleared. More than four counted symbols mark an overflow
// and the letter end is then silent. Word end drops pending symbols and
// emits a space. The reserved action code is accepted and ignored.
// ----------------------------------------------------------------------------
module morse_key_decoder import mkd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mkd_key_if.sink    key_req,
  mkd_char_if.source char_rsp,
  mkd_cfg_if.sink    cfg
);

  // Dash threshold; the user must write it only while the decoder is idle, the block does not enforce this.
  logic [HOLD_W-1:0] dash_ticks;

  // Command hand-off between the front and back parts.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_ticks <= DASH_TICKS_RESET;
    end else if (cfg.valid) begin
      dash_ticks <= cfg.dash_ticks;
    end
  end

  // Front: accept and classify key requests into the command queue.
  mkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_req   (key_req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Back: press timing, symbol collection and letter lookup.
  mkd_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready),
    .dash_ticks (dash_ticks),
    .char_rsp   (char_rsp)
  );

endmodule
`default_nettype wire

// ----- design/mkd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder front
// Accepts key requests, turns each into a command and queues it. Requests
// with the reserved action code are taken and dropped.
// ----------------------------------------------------------------------------
module mkd_front import mkd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mkd_key_if.sink   key_req,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  cmd_t new_cmd;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    new_cmd.kind = CMD_KEY_DOWN;
    keep         = 1'b1;
    case (key_req.action)
      ACT_TICK:   new_cmd.kind = key_req.key_down ? CMD_KEY_DOWN : CMD_KEY_UP;
      ACT_LETTER: new_cmd.kind = CMD_LETTER;
      ACT_WORD:   new_cmd.kind = CMD_WORD;
      default:    keep = 1'b0;
    endcase
  end

  assign key_req.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push          = key_req.valid && key_req.ready && keep;
  assign cmd_valid     = (count != '0);
  assign cmd           = queue[rd_ptr];
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/mkd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder back
// Carries out queued commands: times key presses, collects dots and dashes,
// and decodes letters into a registered output.
// ----------------------------------------------------------------------------
module mkd_back import mkd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_ready,
  input  wire logic [HOLD_W-1:0] dash_ticks,
  mkd_char_if.source             char_rsp
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 2);

  logic [SYMBOL_W-1:0] symbol_bits;
  logic [CNT_W-1:0]    symbol_count;
  logic [HOLD_W-1:0]   hold_ticks;
  logic                dash_sent;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;

  logic [SYMBOL_W-1:0] symbol_bits_next;
  logic [CNT_W-1:0]    symbol_count_next;
  logic [HOLD_W-1:0]   hold_ticks_next;
  logic                dash_sent_next;

  logic [HOLD_W-1:0]   hold_inc;
  logic [SYMBOL_W-1:0] bits_dot;
  logic [SYMBOL_W-1:0] bits_dash;
  logic [CNT_W-1:0]    count_add;
  logic [CHAR_W-1:0]   letter;
  logic [CHAR_W-1:0]   load_char;
  logic                load;
  logic                emits;
  logic                fire;

  // A command that may produce a character waits for room at the output.
  assign emits     = (cmd.kind == CMD_LETTER) || (cmd.kind == CMD_WORD);
  assign cmd_ready = !emits || !out_valid || char_rsp.ready;
  assign fire      = cmd_valid && cmd_ready;

  always_comb begin
    hold_inc  = (hold_ticks != HOLD_MAX) ? hold_ticks + 1'b1 : hold_ticks;
    bits_dot  = symbol_bits;
    bits_dash = (symbol_count < CNT_W'(SYMBOL_W))
              ? (symbol_bits | (SYMBOL_W'(1) << symbol_count[1:0])) : symbol_bits;
    count_add = (symbol_count < CNT_W'(MAX_SYMBOLS + 1))
              ? symbol_count + 1'b1 : symbol_count;
    letter    = ((symbol_count >= CNT_W'(1)) && (symbol_count <= CNT_W'(SYMBOL_W)))
              ? letter_lookup(3'(symbol_count), symbol_bits) : NO_LETTER;

    symbol_bits_next  = symbol_bits;
    symbol_count_next = symbol_count;
    hold_ticks_next   = hold_ticks;
    dash_sent_next    = dash_sent;
    load              = 1'b0;
    load_char         = letter;

    case (cmd.kind)
      CMD_KEY_DOWN: begin
        hold_ticks_next = hold_inc;
        if (!dash_sent && (hold_inc > dash_ticks)) begin
          symbol_bits_next  = bits_dash;
          symbol_count_next = count_add;
          dash_sent_next    = 1'b1;
        end
      end
      CMD_KEY_UP: begin
        if ((hold_ticks != '0) && !dash_sent) begin
          symbol_bits_next  = bits_dot;
          symbol_count_next = count_add;
        end
        hold_ticks_next = '0;
        dash_sent_next  = 1'b0;
      end
      CMD_LETTER: begin
        symbol_bits_next  = '0;
        symbol_count_next = '0;
        load              = (letter != NO_LETTER);
      end
      CMD_WORD: begin
        symbol_bits_next  = '0;
        symbol_count_next = '0;
        load              = 1'b1;
        load_char         = SPACE_CODE;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits  <= '0;
      symbol_count <= '0;
      hold_ticks   <= '0;
      dash_sent    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        symbol_bits  <= symbol_bits_next;
        symbol_count <= symbol_count_next;
        hold_ticks   <= hold_ticks_next;
        dash_sent    <= dash_sent_next;
      end
      if (fire && load) begin
        out_valid <= 1'b1;
      end else if (char_rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load) begin
      out_char <= load_char;
    end
  end

  assign char_rsp.valid     = out_valid;
  assign char_rsp.character = out_char;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder testbench
// Drives key samples, letter ends and word ends into the decoder, predicts
// every decoded character in the bench itself, and compares each character
// that leaves the decoder with the oldest prediction. Directed tests cover
// the corner cases. Random traffic with idle bursts on both channels and
// several dash thresholds follows them.
// ----------------------------------------------------------------------------
module tb_top;
  import mkd_pkg::*;

  // The decoder default for the symbol limit, since the instance keeps it.
  localparam int MAX_SYM = MAX_SYMBOLS_DEFAULT;

  // Action code 3 has no meaning, and the decoder must swallow it.
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  // The slowest correct stretch without any handshake is the long hold-off
  // of the character receiver plus the time a character takes through the
  // decoder; STALL_LIMIT leaves a wide margin over it.
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int MAX_PRINTS = 50;

  logic clk = 1'b0;
  logic rst;

  mkd_key_if  key_req ();
  mkd_char_if char_rsp ();
  mkd_cfg_if  cfg ();

  morse_key_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .key_req  (key_req),
    .char_rsp (char_rsp),
    .cfg      (cfg)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder prediction. These variables mirror the decoder state and are
  // advanced once for every key request that the decoder accepts.
  // --------------------------------------------------------------------------
  logic [HOLD_W-1:0]   dash_thr;
  logic [HOLD_W-1:0]   hold_cnt;
  logic                dash_done;
  logic [SYMBOL_W-1:0] sym_bits;
  logic [2:0]          sym_cnt;

  // Characters that the decoder still owes us, oldest first.
  logic [CHAR_W-1:0] pending_chars [$];

  // Patterns by length: the entry for a pattern of n symbols sits at
  // 2^n - 2 + pattern, with the first symbol in bit 0 and a dash as 1.
  logic [7:0] letter_of [30] = '{
    "e", "t",
    "i", "n", "a", "m",
    "s", "d", "r", "g", "u", "k", "w", "o",
    "h", "b", "l", "z", "f", "c", "p", {1'b0, NO_LETTER},
    "v", "x", {1'b0, NO_LETTER}, "q", {1'b0, NO_LETTER}, "y", "j", {1'b0, NO_LETTER}
  };

  // Bookkeeping for the run summary and the verdict.
  int  err_cnt     = 0;
  int  req_cnt     = 0;
  int  chars_cnt   = 0;
  int  thr_writes  = 0;
  bit  letter_hit [26];
  bit  idle_on     = 1'b1;
  int  rsp_hold    = 0;

  // Appends one symbol. Only four symbols are stored, but the count keeps
  // going up to one past the limit so that an overflow can be told apart.
  function automatic void add_mark(input bit is_dash);
    if (sym_cnt < 3'd4 && is_dash) begin
      sym_bits[sym_cnt[1:0]] = 1'b1;
    end
    if (int'(sym_cnt) <= MAX_SYM) begin
      sym_cnt = sym_cnt + 3'd1;
    end
  endfunction

  // Advances the predicted state by one accepted request and queues the
  // character that the request produces, if any.
  function automatic void decode_step(input logic [ACTION_W-1:0] act, input logic key);
    int         n;
    logic [7:0] code;
    n    = int'(sym_cnt);
    code = '0;
    case (act)
      ACT_TICK: begin
        if (key) begin
          if (hold_cnt != HOLD_MAX) begin
            hold_cnt = hold_cnt + 8'd1;
          end
          // Only the first tick past the threshold makes a dash.
          if (!dash_done && hold_cnt > dash_thr) begin
            add_mark(1'b1);
            dash_done = 1'b1;
          end
        end else begin
          // A release ends the press; a press that never became a dash is a
          // dot, and a release with no press before it adds nothing.
          if (hold_cnt != '0 && !dash_done) begin
            add_mark(1'b0);
          end
          hold_cnt  = '0;
          dash_done = 1'b0;
        end
      end
      ACT_LETTER: begin
        if (n >= 1 && n <= 4 && n <= MAX_SYM) begin
          code = letter_of[(1 << n) - 2 + int'(sym_bits) % (1 << n)];
        end
        sym_bits = '0;
        sym_cnt  = '0;
        if (code != {1'b0, NO_LETTER}) begin
          pending_chars.push_back(code[CHAR_W-1:0]);
        end
      end
      ACT_WORD: begin
        sym_bits = '0;
        sym_cnt  = '0;
        pending_chars.push_back(SPACE_CODE);
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking and bookkeeping at the clock edge.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("%0t ns  MISMATCH: %s", $time, msg);
    end
  endtask

  logic [CHAR_W-1:0] want_char;

  // Every character that the decoder hands over is compared with the oldest
  // prediction. Handshake signals are read in the active region of the edge,
  // so they hold the values that the decoder also saw.
  always @(posedge clk) begin
    if (!rst && char_rsp.valid && char_rsp.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h arrived with none expected",
                                  char_rsp.character));
      end else begin
        want_char = pending_chars.pop_front();
        chars_cnt++;
        if (char_rsp.character !== want_char) begin
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    char_rsp.character, want_char));
        end else if (want_char >= "a" && want_char <= "z") begin
          letter_hit[int'(want_char) - int'("a")] = 1'b1;
        end
      end
    end
  end

  // The watchdog counts cycles in which no channel moves anything. Such a
  // stretch only grows long when the decoder hangs.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (key_req.valid && key_req.ready) || (char_rsp.valid && char_rsp.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // The character receiver. It is mostly ready, drops ready in short random
  // bursts while idling is on, and on request holds off for a long stretch
  // that it counts itself.
  initial begin : char_receiver
    int n;
    char_rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold > 0) begin
        n        = rsp_hold;
        rsp_hold = 0;
        char_rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        char_rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        char_rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Offers one key request and waits until the decoder takes it. Valid is
  // left high afterwards, so that back-to-back requests never lower and
  // raise it within one time step; the next call or an idle lowers it.
  task automatic send_req(input logic [ACTION_W-1:0] act, input logic key);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      key_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    key_req.valid    <= 1'b1;
    key_req.action   <= act;
    key_req.key_down <= key;
    do @(posedge clk); while (!key_req.ready);
    decode_step(act, key);
    if (act != ACT_SPARE) begin
      req_cnt++;
    end
  endtask

  // One key press: held for the given number of ticks, then released for
  // the given number of ticks.
  task automatic key_press(input int held, input int gap);
    repeat (held) send_req(ACT_TICK, 1'b1);
    repeat (gap) send_req(ACT_TICK, 1'b0);
  endtask

  // Keys a pattern of len symbols with random press lengths that fit the
  // current dash threshold, then ends the letter. Symbols past the fourth
  // are random, since only an overflow can come of them.
  task automatic key_letter(input int len, input logic [SYMBOL_W-1:0] pattern);
    int held;
    bit is_dash;
    for (int i = 0; i < len; i++) begin
      is_dash = (i < SYMBOL_W) ? pattern[i] : 1'($urandom);
      if (is_dash) begin
        held = int'(dash_thr) + 1 + $urandom_range(0, 3);
      end else begin
        held = (dash_thr == '0) ? 1 : $urandom_range(1, int'(dash_thr));
      end
      key_press(held, $urandom_range(1, 2));
    end
    send_req(ACT_LETTER, 1'($urandom));
  endtask

  // Stops offering requests and waits until every predicted character has
  // arrived, then lets any request that makes no character but may still
  // sit in the decoder's command queue drain out.
  task automatic wait_idle();
    key_req.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Changes the dash threshold while the decoder is idle.
  task automatic write_dash_ticks(input logic [HOLD_W-1:0] thr);
    wait_idle();
    cfg.valid      <= 1'b1;
    cfg.dash_ticks <= thr;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    dash_thr = thr;
    thr_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Basic decoding at the reset threshold of two ticks.
  task automatic test_basics();
    // The spare action code is swallowed whatever the key level.
    send_req(ACT_SPARE, 1'b1);
    send_req(ACT_SPARE, 1'b0);
    // A letter end with nothing keyed is silent, and so is a bare release.
    send_req(ACT_LETTER, 1'b0);
    send_req(ACT_TICK, 1'b0);
    // Single dot, single dash, and dash dash dot.
    key_letter(1, 4'b0000);
    key_letter(1, 4'b0001);
    key_letter(3, 4'b0011);
    // A word end drops a pending dot and still gives a space.
    key_press(1, 1);
    send_req(ACT_WORD, 1'b1);
    // A letter end in the middle of a press leaves the press timer alone:
    // the next held tick, the third of the press, still makes a dash.
    key_press(2, 0);
    send_req(ACT_LETTER, 1'b1);
    key_press(1, 1);
    send_req(ACT_LETTER, 1'b0);
  endtask

  // Too many symbols, a four-symbol pattern that is not a letter, and h.
  task automatic test_overflow();
    key_letter(5, 4'b0000);
    key_letter(6, 4'($urandom));
    key_letter(4, 4'b1100);
    key_letter(4, 4'b0000);
  endtask

  // Dash threshold at its extremes and at one.
  task automatic test_thresholds();
    // At zero the first held tick makes a dash, and a long press still
    // makes only one.
    write_dash_ticks(8'd0);
    key_press(1, 1);
    key_press(4, 1);
    send_req(ACT_LETTER, 1'b0);
    // At 255 the hold timer saturates, so even a very long press is a dot.
    write_dash_ticks(8'd255);
    key_press(260, 1);
    send_req(ACT_LETTER, 1'b1);
    write_dash_ticks(8'd1);
    key_letter(2, 4'b0010);
  endtask

  // The receiver holds off for a long stretch while letters and word ends
  // that each make a character keep coming, so the command queue fills and
  // key_req.ready drops.
  task automatic test_backpressure();
    rsp_hold = HOLD_OFF_CYCLES;
    repeat (8) begin
      key_letter(1, 4'($urandom));
      send_req(ACT_WORD, 1'($urandom));
    end
  endtask

  // The sender pauses until every character is out, then carries on.
  task automatic test_drain_pause();
    key_letter(2, 4'($urandom));
    wait_idle();
    key_letter(3, 4'($urandom));
    send_req(ACT_WORD, 1'b0);
  endtask

  // Random words of random letters across several thresholds. Most traffic
  // is well-formed keying; some noise requests and overlong letters break
  // the sequences now and then. The second and last phases run without idling.
  task automatic test_random_traffic();
    int goal;
    int len;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_dash_ticks(8'd0);
        1:       write_dash_ticks(8'd3);
        2:       write_dash_ticks(8'($urandom_range(1, 6)));
        3:       write_dash_ticks(8'd2);
        4:       write_dash_ticks(8'($urandom_range(0, 5)));
        default: write_dash_ticks(8'd1);
      endcase
      idle_on = (ph != 1 && ph != 5);
      goal    = req_cnt + 80;
      while (req_cnt < goal) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) send_req(2'($urandom), 1'($urandom));
          end
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
          key_letter(len, 4'($urandom));
        end
        send_req(ACT_WORD, 1'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int hit;
    rst              <= 1'b1;
    key_req.valid    <= 1'b0;
    key_req.action   <= ACT_TICK;
    key_req.key_down <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.dash_ticks   <= DASH_TICKS_RESET;
    dash_thr  = DASH_TICKS_RESET;
    hold_cnt  = '0;
    dash_done = 1'b0;
    sym_bits  = '0;
    sym_cnt   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_basics();
    test_overflow();
    test_thresholds();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    wait_idle();

    hit = 0;
    foreach (letter_hit[i]) hit += int'(letter_hit[i]);
    $display("Covered %0d key requests and %0d checked characters, %0d of 26 letters,",
             req_cnt, chars_cnt, hit);
    $display("with %0d dash threshold changes and %0d mismatches.", thr_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
